// File: rtl/fcad_pkg.sv
// Shared types, constants and the elementary angle table for the atan2 degree pipeline.
package fcad_pkg;

  localparam int CORDIC_W = 64;   // vector datapath width
  localparam int ZFRAC    = 32;   // fraction bits of the angle accumulator
  localparam int Z_W      = 41;   // signed accumulator width, covers +/- 100 deg
  localparam int TAB_SIZE = 32;
  localparam int GUARD_TOP = 60;  // coordinates sit left-aligned below this bit

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef enum logic [2:0] {
    AXIS_NONE = 3'd0,
    AXIS_0    = 3'd1,   // positive x axis and the origin
    AXIS_90   = 3'd2,
    AXIS_180  = 3'd3,
    AXIS_270  = 3'd4
  } axis_t;

  typedef struct packed {
    axis_t axis;
    quad_t quad;
  } ctl_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic signed [Z_W-1:0]      z;
    ctl_t                       ctl;
  } cordic_t;

  // Restoring divide, elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], a[k]};
      if (rem >= {1'b0, b}) begin
        rem = rem - {1'b0, b};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n), 56 fraction bits, alternating Taylor sum
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] pw;
    logic [63:0] n2;
    logic [63:0] sum;
    logic [63:0] term;
    pw  = udiv64(64'd1 << 56, n);
    n2  = n * n;
    sum = '0;
    for (int k = 0; k < 200; k++) begin
      if (pw != 64'd0) begin
        term = udiv64(pw, 64'(2 * k + 1));
        if (k[0])
          sum = sum - term;
        else
          sum = sum + term;
        pw = udiv64(pw, n2);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in degrees, 32 fraction bits, truncated
  function automatic logic [63:0] elem_angle(input int idx);
    logic [63:0] q;
    logic [63:0] num;
    logic [63:0] ip;
    logic [63:0] r;
    logic [63:0] fr;
    if (idx == 0)
      return 64'd45 << ZFRAC;
    q   = 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
    num = 64'd45 * atan_recip(64'd1 << idx);
    ip  = udiv64(num, q);
    r   = num - ip * q;
    fr  = '0;
    for (int b = 0; b < ZFRAC; b++) begin
      r  = r << 1;
      fr = fr << 1;
      if (r >= q) begin
        r  = r - q;
        fr = fr | 64'd1;
      end
    end
    return (ip << ZFRAC) | fr;
  endfunction

endpackage

// File: rtl/fcad_front.sv
// Input stage: special-case and quadrant classification, magnitudes into CORDIC format.
module fcad_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fcad_pkg::cordic_t           data_o
);

  localparam int GUARD = fcad_pkg::GUARD_TOP - COORD_WIDTH;

  logic                     valid_r;
  fcad_pkg::cordic_t        data_r;
  fcad_pkg::cordic_t        data_nxt;
  logic [COORD_WIDTH-1:0]   ax;
  logic [COORD_WIDTH-1:0]   ay;
  logic                     x_zero;
  logic                     y_zero;

  assign x_zero = (x_i == '0);
  assign y_zero = (y_i == '0);
  // -(most negative) wraps to 2^(W-1), which is the right unsigned magnitude
  assign ax = x_i[COORD_WIDTH-1] ? COORD_WIDTH'(-x_i) : COORD_WIDTH'(x_i);
  assign ay = y_i[COORD_WIDTH-1] ? COORD_WIDTH'(-y_i) : COORD_WIDTH'(y_i);

  always_comb begin
    data_nxt.cx = $signed(fcad_pkg::CORDIC_W'(ax) << GUARD);
    data_nxt.cy = $signed(fcad_pkg::CORDIC_W'(ay) << GUARD);
    data_nxt.z  = '0;
    if (x_zero && y_zero)
      data_nxt.ctl.axis = fcad_pkg::AXIS_0;
    else if (x_zero)
      data_nxt.ctl.axis = y_i[COORD_WIDTH-1] ? fcad_pkg::AXIS_270 : fcad_pkg::AXIS_90;
    else if (y_zero)
      data_nxt.ctl.axis = x_i[COORD_WIDTH-1] ? fcad_pkg::AXIS_180 : fcad_pkg::AXIS_0;
    else
      data_nxt.ctl.axis = fcad_pkg::AXIS_NONE;
    case ({x_i[COORD_WIDTH-1], y_i[COORD_WIDTH-1]})
      2'b00:   data_nxt.ctl.quad = fcad_pkg::QUAD_I;
      2'b10:   data_nxt.ctl.quad = fcad_pkg::QUAD_II;
      2'b11:   data_nxt.ctl.quad = fcad_pkg::QUAD_III;
      default: data_nxt.ctl.quad = fcad_pkg::QUAD_IV;
    endcase
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else if (in_ready)
      valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign data_o    = data_r;

endmodule

// File: rtl/fcad_cordic_stage.sv
// One vectoring-mode CORDIC micro-rotation with its pipeline register.
module fcad_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcad_pkg::cordic_t data_i,
  output logic              out_valid,
  input  logic              out_ready,
  output fcad_pkg::cordic_t data_o
);

  localparam logic signed [fcad_pkg::Z_W-1:0] ANG_Z =
    fcad_pkg::Z_W'(fcad_pkg::elem_angle(IDX));

  logic                                  valid_r;
  fcad_pkg::cordic_t                     data_r;
  fcad_pkg::cordic_t                     data_nxt;
  logic signed [fcad_pkg::CORDIC_W-1:0]  cx;
  logic signed [fcad_pkg::CORDIC_W-1:0]  cy;
  logic signed [fcad_pkg::CORDIC_W-1:0]  dx;
  logic signed [fcad_pkg::CORDIC_W-1:0]  dy;

  assign cx = data_i.cx;
  assign cy = data_i.cy;
  assign dx = cy >>> IDX;
  assign dy = cx >>> IDX;

  always_comb begin
    data_nxt.ctl = data_i.ctl;
    if (!cy[fcad_pkg::CORDIC_W-1]) begin
      data_nxt.cx = cx + dx;
      data_nxt.cy = cy - dy;
      data_nxt.z  = data_i.z + ANG_Z;
    end else begin
      data_nxt.cx = cx - dx;
      data_nxt.cy = cy + dy;
      data_nxt.z  = data_i.z - ANG_Z;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else if (in_ready)
      valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign data_o    = data_r;

endmodule

// File: rtl/fcad_back.sv
// Output stages: clamp and round the angle, then place it by quadrant or axis.
module fcad_back #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fcad_pkg::cordic_t            data_i,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ANGLE_FRAC_BITS+8:0]   angle_o
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int OUT_W = F + 9;
  localparam int PHI_W = F + 7;
  localparam int ZU_W  = fcad_pkg::ZFRAC + 8;   // 0..90 deg plus rounding carry
  localparam logic signed [fcad_pkg::Z_W-1:0] ZMAX =
    fcad_pkg::Z_W'(90) <<< fcad_pkg::ZFRAC;
  localparam logic [ZU_W-1:0] RND = ZU_W'(1) << (fcad_pkg::ZFRAC - 1 - F);
  localparam logic [OUT_W-1:0] DEG_90  = OUT_W'(90)  << F;
  localparam logic [OUT_W-1:0] DEG_180 = OUT_W'(180) << F;
  localparam logic [OUT_W-1:0] DEG_270 = OUT_W'(270) << F;
  localparam logic [OUT_W-1:0] DEG_360 = OUT_W'(360) << F;

  // stage A: clamp and round
  logic                  valid_a_r;
  logic                  ready_a;
  logic [PHI_W-1:0]      phi_a_r;
  logic [PHI_W-1:0]      phi_a_nxt;
  fcad_pkg::ctl_t        ctl_a_r;
  logic [ZU_W-1:0]       z_clamp;
  logic [ZU_W-1:0]       z_rnd;

  // stage B: placement, doubles as output register
  logic                  valid_b_r;
  logic                  ready_b;
  logic [OUT_W-1:0]      angle_b_r;
  logic [OUT_W-1:0]      angle_b_nxt;
  logic [OUT_W-1:0]      phi_ext;

  always_comb begin
    if (data_i.z < 0)
      z_clamp = '0;
    else if (data_i.z > ZMAX)
      z_clamp = ZU_W'(ZMAX);
    else
      z_clamp = ZU_W'(data_i.z);
    z_rnd     = z_clamp + RND;
    phi_a_nxt = z_rnd[fcad_pkg::ZFRAC-F +: PHI_W];
  end

  assign ready_a  = !valid_a_r || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_a_r <= 1'b0;
    else if (ready_a)
      valid_a_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      phi_a_r <= phi_a_nxt;
      ctl_a_r <= data_i.ctl;
    end
  end

  assign phi_ext = OUT_W'(phi_a_r);

  always_comb begin
    case (ctl_a_r.axis)
      fcad_pkg::AXIS_0:   angle_b_nxt = '0;
      fcad_pkg::AXIS_90:  angle_b_nxt = DEG_90;
      fcad_pkg::AXIS_180: angle_b_nxt = DEG_180;
      fcad_pkg::AXIS_270: angle_b_nxt = DEG_270;
      default: begin
        case (ctl_a_r.quad)
          fcad_pkg::QUAD_I:   angle_b_nxt = phi_ext;
          fcad_pkg::QUAD_II:  angle_b_nxt = DEG_180 - phi_ext;
          fcad_pkg::QUAD_III: angle_b_nxt = DEG_180 + phi_ext;
          default: begin
            // a zero angle below the x axis lands on 360 and wraps
            angle_b_nxt = (phi_ext == '0) ? '0 : DEG_360 - phi_ext;
          end
        endcase
      end
    endcase
  end

  assign ready_b = !valid_b_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_b_r <= 1'b0;
    else if (ready_b)
      valid_b_r <= valid_a_r;
  end

  always_ff @(posedge clk) begin
    if (ready_b && valid_a_r)
      angle_b_r <= angle_b_nxt;
  end

  assign out_valid = valid_b_r;
  assign angle_o   = angle_b_r;

endmodule

// File: rtl/full_circle_angle_degrees.sv
// Top level: pipelined CORDIC atan2 giving the full-circle angle in degrees.
// Pipeline: one classify stage, one register per micro-rotation, clamp/round, placement.
// Throughput: one transaction per cycle while out_tready stays high; every stage holds
//   its own valid bit and takes new data whenever it is empty or its successor moves on.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
module full_circle_angle_degrees #(
  parameter int COORD_WIDTH     = 24,   // 8..32
  parameter int ANGLE_FRAC_BITS = 16,   // 8..24
  parameter int ITERATIONS      = 20    // 8..32 micro-rotations
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input vector stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // fields from bit 0: vec_x[COORD_WIDTH], vec_y[COORD_WIDTH], zero fill to bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // angle stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // fields from bit 0: angle_deg[ANGLE_FRAC_BITS+9], zero fill to bytes
  output logic [((ANGLE_FRAC_BITS+9+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_W       = ANGLE_FRAC_BITS + 9;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  logic signed [COORD_WIDTH-1:0] vec_x;
  logic signed [COORD_WIDTH-1:0] vec_y;
  logic [OUT_W-1:0]              angle_deg;

  // one slot per pipeline boundary: slot 0 is the classify stage output,
  // slot k the output of micro-rotation k-1
  fcad_pkg::cordic_t stage_data  [ITERATIONS+1];
  logic              stage_valid [ITERATIONS+1];
  logic              stage_ready [ITERATIONS+1];

  assign vec_x = $signed(in_tdata[COORD_WIDTH-1:0]);
  assign vec_y = $signed(in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);

  // Axis points and the origin are resolved here and ride along the
  // pipeline as a control tag; the CORDIC sees |x| and |y| only.
  fcad_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .x_i      (vec_x),
    .y_i      (vec_y),
    .out_valid(stage_valid[0]),
    .out_ready(stage_ready[0]),
    .data_o   (stage_data[0])
  );

  // One register stage per micro-rotation: a 64-bit add on each of x and y
  // plus the angle accumulate, shift amount fixed per stage.
  for (genvar gi = 0; gi < ITERATIONS; gi++) begin : g_rot
    fcad_cordic_stage #(
      .IDX(gi)
    ) u_rot (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stage_valid[gi]),
      .in_ready (stage_ready[gi]),
      .data_i   (stage_data[gi]),
      .out_valid(stage_valid[gi+1]),
      .out_ready(stage_ready[gi+1]),
      .data_o   (stage_data[gi+1])
    );
  end

  // Clamp to [0, 90], round half up, then apply the axis or quadrant rule.
  // The final stage register is the output register.
  fcad_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stage_valid[ITERATIONS]),
    .in_ready (stage_ready[ITERATIONS]),
    .data_i   (stage_data[ITERATIONS]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .angle_o  (angle_deg)
  );

  assign out_tdata = OUT_TDATA_W'(angle_deg);

endmodule

// File: tb/tb.sv
// Self-checking stream testbench for the full-circle atan2 angle pipeline.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration under test (defaults of the RTL)
  localparam int CW    = 24;                    // coordinate width
  localparam int FRAC  = 16;                    // angle fraction bits
  localparam int STEPS = 20;                    // micro-rotations
  localparam int ANG_W = FRAC + 9;              // angle field width
  localparam int IN_W  = ((2 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((ANG_W + 7) / 8) * 8;
  localparam int LATENCY = STEPS + 3;

  // Accumulator format: degrees with 32 fraction bits, coordinates left-aligned below bit 60
  localparam int ZF    = 32;
  localparam int SHIFT = 60 - CW;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam longint unsigned DEG_90  = 64'd90  << FRAC;
  localparam longint unsigned DEG_180 = 64'd180 << FRAC;
  localparam longint unsigned DEG_270 = 64'd270 << FRAC;
  localparam longint unsigned DEG_360 = 64'd360 << FRAC;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // from bit 0: vec_x[24], vec_y[24]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // from bit 0: angle_deg[25], zero fill

  // Elementary angles atan(2^-i) in degrees, 32 fraction bits, truncated
  longint unsigned  atan_deg [STEPS];

  logic [ANG_W-1:0] angle_q [$];     // expected angles, oldest first
  int               n_errors = 0;
  int               idle_pct = 0;    // sender idle chance per cycle, percent
  int               stall_pct = 0;   // receiver stall chance per cycle, percent

  full_circle_angle_degrees #(
    .COORD_WIDTH     (CW),
    .ANGLE_FRAC_BITS (FRAC),
    .ITERATIONS      (STEPS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------------

  // atan(1/n) with 56 fraction bits, alternating Taylor series
  function automatic longint unsigned atan_inv(input longint unsigned n);
    longint unsigned pw;
    longint unsigned n2;
    longint unsigned acc;
    pw  = (64'd1 << 56) / n;
    n2  = n * n;
    acc = 0;
    for (int k = 0; k < 200 && pw != 0; k++) begin
      if (k % 2)
        acc = acc - pw / 64'(2 * k + 1);
      else
        acc = acc + pw / 64'(2 * k + 1);
      pw = pw / n2;
    end
    return acc;
  endfunction

  // Degrees = 45 * atan(2^-i) / (pi/4); pi/4 from Machin's formula, long division for fraction
  function automatic void build_atan_deg();
    longint unsigned quarter_pi;
    longint unsigned num;
    longint unsigned ipart;
    longint unsigned rem;
    longint unsigned fpart;
    quarter_pi = 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
    atan_deg[0] = 64'd45 << ZF;
    for (int i = 1; i < STEPS; i++) begin
      num   = 64'd45 * atan_inv(64'd1 << i);
      ipart = num / quarter_pi;
      rem   = num % quarter_pi;
      fpart = 0;
      for (int b = 0; b < ZF; b++) begin
        rem   = rem << 1;
        fpart = fpart << 1;
        if (rem >= quarter_pi) begin
          rem   = rem - quarter_pi;
          fpart = fpart | 64'd1;
        end
      end
      atan_deg[i] = (ipart << ZF) | fpart;
    end
  endfunction

  // First-quadrant angle of (ax, ay), both positive, rounded half up to FRAC bits
  function automatic longint unsigned vectoring_angle(input longint ax, input longint ay);
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint z;
    cx = ax << SHIFT;
    cy = ay << SHIFT;
    z  = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + longint'(atan_deg[i]);
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - longint'(atan_deg[i]);
      end
    end
    if (z < 0)
      z = 0;
    if (z > (longint'(90) << ZF))
      z = longint'(90) << ZF;
    return ($unsigned(z) + (64'd1 << (ZF - 1 - FRAC))) >> (ZF - FRAC);
  endfunction

  // Full-circle angle: axes exact, otherwise quadrant placement of phi, 360 wraps to 0
  function automatic logic [ANG_W-1:0] polar_angle(input logic signed [CW-1:0] x,
                                                   input logic signed [CW-1:0] y);
    longint          ax;
    longint          ay;
    longint unsigned phi;
    longint unsigned deg;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    if (x == 0 && y == 0)
      deg = 0;
    else if (x == 0)
      deg = (y > 0) ? DEG_90 : DEG_270;
    else if (y == 0)
      deg = (x > 0) ? 0 : DEG_180;
    else begin
      phi = vectoring_angle(ax, ay);
      if (x > 0 && y > 0)
        deg = phi;
      else if (x < 0 && y > 0)
        deg = DEG_180 - phi;
      else if (x < 0)
        deg = DEG_180 + phi;
      else
        deg = DEG_360 - phi;
      if (deg >= DEG_360)
        deg = deg - DEG_360;
    end
    return deg[ANG_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on every input transaction, compare on every output transaction.
  // Prediction is queued before the compare so a same-edge result still finds it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [ANG_W-1:0] want;
    logic [ANG_W-1:0] got;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        angle_q.push_back(polar_angle(in_tdata[CW-1:0], in_tdata[2*CW-1:CW]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[ANG_W-1:0];
        if (angle_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 200)
            $display("%0t ERROR unexpected angle transaction: expected none, got %0d",
                     $time, got);
        end else begin
          want = angle_q.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 200)
              $display("%0t ERROR angle_deg: expected %0d, got %0d", $time, want, got);
          end
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One vector transaction; valid stays high across back-to-back transactions
  task automatic send_vector(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-2*CW){1'b0}}, y, x};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  // Hold off the sender until every queued angle has come back
  task automatic drain_angles();
    in_tvalid <= 1'b0;
    while (angle_q.size() != 0)
      @(posedge clk);
  endtask

  // Origin, the four half-axes, and axis points at full scale
  task automatic test_axes();
    send_vector(0, 0);
    send_vector(1, 0);
    send_vector(-1, 0);
    send_vector(0, 1);
    send_vector(0, -1);
    send_vector(C_MAX, 0);
    send_vector(C_MIN, 0);
    send_vector(0, C_MAX);
    send_vector(0, C_MIN);
  endtask

  // Diagonals, most negative magnitudes, and near-axis points that round onto 0/360
  task automatic test_corners();
    send_vector(C_MIN, C_MIN);
    send_vector(C_MAX, C_MAX);
    send_vector(C_MIN, C_MAX);
    send_vector(C_MAX, C_MIN);
    send_vector(1, 1);
    send_vector(-1, 1);
    send_vector(-1, -1);
    send_vector(1, -1);
    send_vector(C_MAX, 1);
    send_vector(C_MAX, -1);      // just under 360, rounds to full circle and wraps
    send_vector(C_MIN, 1);
    send_vector(C_MIN, -1);
    send_vector(1, C_MAX);
    send_vector(-1, C_MIN);
    send_vector(3, 4);
  endtask

  // Random vectors mixing full-range values with axis, tiny, diagonal and near-axis cases
  task automatic test_random_stream(input int n_items, input int idle, input int stall);
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    int                   kind;
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < n_items; n++) begin
      x    = CW'($urandom);
      y    = CW'($urandom);
      kind = $urandom_range(11);
      case (kind)
        0: if ($urandom_range(1)) x = '0; else y = '0;
        1: begin
          x = CW'(int'($urandom_range(8)) - 4);
          y = CW'(int'($urandom_range(8)) - 4);
        end
        2: y = $urandom_range(1) ? x : -x;
        3: if ($urandom_range(1)) y = CW'(int'($urandom_range(4)) - 2);
           else x = CW'(int'($urandom_range(4)) - 2);
        4: if ($urandom_range(1)) x = C_MIN; else y = C_MIN;
        default: ;
      endcase
      send_vector(x, y);
    end
    drain_angles();
  endtask

  initial begin
    build_atan_deg();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_axes();
    test_corners();
    drain_angles();

    // phases: free running, sparse sender, heavy back-pressure, both throttled
    test_random_stream(480, 0, 0);
    test_random_stream(470, 84, 0);
    test_random_stream(470, 0, 84);
    test_random_stream(470, 37, 37);

    // let any stray transaction surface before the verdict
    stall_pct = 0;
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && angle_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
